FILE: rtl/core/max_pool_2d_argmax_defines.svh
// assertion macros for the max pooling block
`ifndef MAX_POOL_2D_ARGMAX_DEFINES_SVH
`define MAX_POOL_2D_ARGMAX_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MP2A_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MP2A_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mp2a_pkg.sv
// shared constants, types and state encodings of the max pooling block
`timescale 1ns / 1ps

package mp2a_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_KERNEL  = 8;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;

  localparam int LANE_BITS  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int KSIZE_BITS = $clog2(MAX_KERNEL + 1);
  localparam int WORD_BITS  = MAX_KERNEL * SAMPLE_BITS;

  localparam int ROW_BITS     = 12;
  localparam int OUT_COL_BITS = 10;
  localparam int KREG_BITS    = 4;
  localparam int STRIDE_BITS  = 4;
  localparam int WIDTH_BITS   = 11;
  localparam int HEIGHT_BITS  = 13;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 13;

  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 2'd3;

  localparam logic [KREG_BITS-1:0]   KERNEL_RESET = 4'd2;
  localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 4'd2;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd256;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } pool_state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_ISSUE,
    SC_DRAIN
  } scan_state_t;

  typedef struct packed {
    logic [COL_BITS-1:0]   col0;
    logic [KSIZE_BITS-1:0] ksize;
    logic [LANE_BITS-1:0]  lane_top;
  } scan_cmd_t;

  typedef struct packed {
    logic                          done;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [LANE_BITS-1:0]          row_off;
    logic [LANE_BITS-1:0]          col_off;
  } scan_res_t;

endpackage

FILE: rtl/core/max_pool_2d_argmax.sv
// max_pool_2d_argmax top level: streaming K x K max pooling with argmax over raster-order
// samples, one channel after another. Every sample is written into a line store of one word
// per column with one lane per buffered row (1024 words of 8 lanes). A sample that does not
// close a window is only written into the store. A sample that is the bottom-right corner of
// a stride-aligned window also starts a scan: the window is read back one column per cycle
// through the single read port of the line store (K reads), then a column reduce stage and a
// merge stage finish the maximum and the result is handed to the output register. Results
// wait in that register while the next samples are taken. The line store needs no clearing
// pass after reset, since a window only covers entries already written for the current
// image. Any configuration write restarts the image at row 0, column 0.
`timescale 1ns / 1ps
`include "max_pool_2d_argmax_defines.svh"

module max_pool_2d_argmax (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [mp2a_pkg::SAMPLE_BITS-1:0] max_value,
  output logic [mp2a_pkg::ROW_BITS-1:0]           max_row,
  output logic [mp2a_pkg::OUT_COL_BITS-1:0]       max_col,
  output logic [mp2a_pkg::ROW_BITS-1:0]           out_row,
  output logic [mp2a_pkg::OUT_COL_BITS-1:0]       out_col,
  output logic                                    channel_end,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mp2a_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [mp2a_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  mp2a_pkg::pool_state_t state;
  mp2a_pkg::pool_state_t state_next;

  logic [mp2a_pkg::KREG_BITS-1:0]   pool_kernel;
  logic [mp2a_pkg::STRIDE_BITS-1:0] stride;
  logic [mp2a_pkg::WIDTH_BITS-1:0]  image_width;
  logic [mp2a_pkg::HEIGHT_BITS-1:0] image_height;

  logic [mp2a_pkg::KSIZE_BITS-1:0]  k_eff;
  logic [mp2a_pkg::STRIDE_BITS-1:0] s_eff;
  logic [mp2a_pkg::COL_BITS:0]      w_eff;
  logic [mp2a_pkg::HEIGHT_BITS-1:0] h_eff;

  logic [mp2a_pkg::ROW_BITS-1:0]    row_count;
  logic [mp2a_pkg::COL_BITS-1:0]    col_count;
  logic [mp2a_pkg::LANE_BITS-1:0]   row_lane;
  logic [mp2a_pkg::STRIDE_BITS-1:0] row_phase;
  logic [mp2a_pkg::STRIDE_BITS-1:0] col_phase;
  logic [mp2a_pkg::ROW_BITS-1:0]    pool_row;
  logic [mp2a_pkg::COL_BITS-1:0]    pool_col;

  logic [mp2a_pkg::ROW_BITS-1:0]    win_row0;
  logic [mp2a_pkg::COL_BITS-1:0]    win_col0;
  logic [mp2a_pkg::ROW_BITS-1:0]    win_orow;
  logic [mp2a_pkg::COL_BITS-1:0]    win_ocol;
  logic                             win_last;

  logic                             fits;
  logic                             row_on;
  logic                             col_on;
  logic                             row_end;
  logic                             col_end;
  logic                             win_hit;
  logic                             last_calc;
  logic [mp2a_pkg::ROW_BITS-1:0]    row0_calc;
  logic [mp2a_pkg::COL_BITS-1:0]    col0_calc;

  logic                             in_fire;
  logic                             cfg_fire;
  logic                             out_free;
  logic                             out_load;

  mp2a_pkg::scan_cmd_t              scan_cmd;
  mp2a_pkg::scan_res_t              scan_res;
  logic                             rd_en;
  logic [mp2a_pkg::COL_BITS-1:0]    rd_addr;
  logic [mp2a_pkg::WORD_BITS-1:0]   rd_data;

  // effective geometry: zero means one, large values saturate
  always_comb begin
    if (pool_kernel == '0) begin
      k_eff = mp2a_pkg::KSIZE_BITS'(1);
    end else if (int'(pool_kernel) > mp2a_pkg::MAX_KERNEL) begin
      k_eff = mp2a_pkg::KSIZE_BITS'(mp2a_pkg::MAX_KERNEL);
    end else begin
      k_eff = mp2a_pkg::KSIZE_BITS'(pool_kernel);
    end
    s_eff = (stride == '0) ? mp2a_pkg::STRIDE_BITS'(1) : stride;
    if (image_width == '0) begin
      w_eff = (mp2a_pkg::COL_BITS+1)'(1);
    end else if (int'(image_width) > mp2a_pkg::MAX_WIDTH) begin
      w_eff = (mp2a_pkg::COL_BITS+1)'(mp2a_pkg::MAX_WIDTH);
    end else begin
      w_eff = (mp2a_pkg::COL_BITS+1)'(image_width);
    end
    if (image_height == '0) begin
      h_eff = mp2a_pkg::HEIGHT_BITS'(1);
    end else if (int'(image_height) > mp2a_pkg::MAX_HEIGHT) begin
      h_eff = mp2a_pkg::HEIGHT_BITS'(mp2a_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // window detection from the running counters, phases stand in for origin mod stride
  always_comb begin
    fits    = (int'(k_eff) <= int'(w_eff)) && (int'(k_eff) <= int'(h_eff));
    row_on  = (int'(row_count) + 1 >= int'(k_eff));
    col_on  = (int'(col_count) + 1 >= int'(k_eff));
    row_end = (int'(row_count) + 1 == int'(h_eff));
    col_end = (int'(col_count) + 1 == int'(w_eff));
    win_hit = fits && row_on && col_on && (row_phase == '0) && (col_phase == '0);
    // last window: no further origin fits below or to the right
    last_calc = (int'(row_count) + int'(s_eff) >= int'(h_eff)) &&
                (int'(col_count) + int'(s_eff) >= int'(w_eff));
    row0_calc = row_count - mp2a_pkg::ROW_BITS'(k_eff - mp2a_pkg::KSIZE_BITS'(1));
    col0_calc = col_count - mp2a_pkg::COL_BITS'(k_eff - mp2a_pkg::KSIZE_BITS'(1));
  end

  assign in_fire  = in_valid && in_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_kernel  <= mp2a_pkg::KERNEL_RESET;
      stride       <= mp2a_pkg::STRIDE_RESET;
      image_width  <= mp2a_pkg::WIDTH_RESET;
      image_height <= mp2a_pkg::HEIGHT_RESET;
      row_count    <= '0;
      col_count    <= '0;
      row_lane     <= '0;
      row_phase    <= '0;
      col_phase    <= '0;
      pool_row     <= '0;
      pool_col     <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        mp2a_pkg::REG_KERNEL: pool_kernel  <= cfg_data[mp2a_pkg::KREG_BITS-1:0];
        mp2a_pkg::REG_STRIDE: stride       <= cfg_data[mp2a_pkg::STRIDE_BITS-1:0];
        mp2a_pkg::REG_WIDTH:  image_width  <= cfg_data[mp2a_pkg::WIDTH_BITS-1:0];
        mp2a_pkg::REG_HEIGHT: image_height <= cfg_data[mp2a_pkg::HEIGHT_BITS-1:0];
        default: ;
      endcase
      row_count <= '0;
      col_count <= '0;
      row_lane  <= '0;
      row_phase <= '0;
      col_phase <= '0;
      pool_row  <= '0;
      pool_col  <= '0;
    end else if (in_fire) begin
      if (col_end) begin
        col_count <= '0;
        col_phase <= '0;
        pool_col  <= '0;
        if (row_end) begin
          row_count <= '0;
          row_lane  <= '0;
          row_phase <= '0;
          pool_row  <= '0;
        end else begin
          row_count <= row_count + mp2a_pkg::ROW_BITS'(1);
          row_lane  <= (row_lane == mp2a_pkg::LANE_BITS'(mp2a_pkg::MAX_KERNEL - 1)) ?
                       '0 : row_lane + mp2a_pkg::LANE_BITS'(1);
          if (row_on) begin
            if (row_phase == s_eff - mp2a_pkg::STRIDE_BITS'(1)) begin
              row_phase <= '0;
              pool_row  <= pool_row + mp2a_pkg::ROW_BITS'(1);
            end else begin
              row_phase <= row_phase + mp2a_pkg::STRIDE_BITS'(1);
            end
          end
        end
      end else begin
        col_count <= col_count + mp2a_pkg::COL_BITS'(1);
        if (col_on) begin
          if (col_phase == s_eff - mp2a_pkg::STRIDE_BITS'(1)) begin
            col_phase <= '0;
            pool_col  <= pool_col + mp2a_pkg::COL_BITS'(1);
          end else begin
            col_phase <= col_phase + mp2a_pkg::STRIDE_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && win_hit) begin
      win_row0 <= row0_calc;
      win_col0 <= col0_calc;
      win_orow <= pool_row;
      win_ocol <= pool_col;
      win_last <= last_calc;
    end
  end

  always_comb begin
    scan_cmd.col0     = col0_calc;
    scan_cmd.ksize    = k_eff;
    scan_cmd.lane_top = row_lane;
  end

  mp2a_line_mem u_line_mem (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (col_count),
    .wr_lane (row_lane),
    .wr_data (sample),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mp2a_win_scan u_win_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (in_fire && win_hit),
    .cmd     (scan_cmd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .res     (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mp2a_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mp2a_pkg::ST_IDLE: begin
        if (in_fire && win_hit) state_next = mp2a_pkg::ST_SCAN;
      end
      mp2a_pkg::ST_SCAN: begin
        if (scan_res.done) begin
          state_next = out_free ? mp2a_pkg::ST_IDLE : mp2a_pkg::ST_HOLD;
        end
      end
      mp2a_pkg::ST_HOLD: begin
        if (out_free) state_next = mp2a_pkg::ST_IDLE;
      end
      default: state_next = mp2a_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == mp2a_pkg::ST_IDLE) && !cfg_valid;
    cfg_ready = (state == mp2a_pkg::ST_IDLE);
    out_load  = ((state == mp2a_pkg::ST_SCAN) && scan_res.done && out_free) ||
                ((state == mp2a_pkg::ST_HOLD) && out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      max_value   <= scan_res.value;
      max_row     <= win_row0 + mp2a_pkg::ROW_BITS'(scan_res.row_off);
      max_col     <= mp2a_pkg::OUT_COL_BITS'(win_col0 + mp2a_pkg::COL_BITS'(scan_res.col_off));
      out_row     <= win_orow;
      out_col     <= mp2a_pkg::OUT_COL_BITS'(win_ocol);
      channel_end <= win_last;
    end
  end

  `MP2A_ASSERT_SAME(a_done_in_scan, clk, rst, scan_res.done, state == mp2a_pkg::ST_SCAN, "scan finished outside the scan state")
  `MP2A_ASSERT_NEXT(a_hit_starts_scan, clk, rst, in_fire && win_hit, state == mp2a_pkg::ST_SCAN, "window corner did not start a scan")
  `MP2A_ASSERT_SAME(a_col_in_range, clk, rst, 1'b1, int'(col_count) < int'(w_eff), "column counter beyond image width")
  `MP2A_ASSERT_NEXT(a_hold_waits, clk, rst, (state == mp2a_pkg::ST_HOLD) && out_valid && !out_ready, state == mp2a_pkg::ST_HOLD, "result left hold while output occupied")

endmodule

FILE: rtl/core/mp2a_line_mem.sv
// line store: one word per column, one lane per buffered row, registered read
`timescale 1ns / 1ps

module mp2a_line_mem (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [mp2a_pkg::COL_BITS-1:0]        wr_addr,
  input  logic [mp2a_pkg::LANE_BITS-1:0]       wr_lane,
  input  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] wr_data,
  input  logic                                 rd_en,
  input  logic [mp2a_pkg::COL_BITS-1:0]        rd_addr,
  output logic [mp2a_pkg::WORD_BITS-1:0]       rd_data
);

  logic [mp2a_pkg::WORD_BITS-1:0] mem [mp2a_pkg::MAX_WIDTH];

  // lane-masked write, the other rows of the column keep their samples
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][wr_lane*mp2a_pkg::SAMPLE_BITS +: mp2a_pkg::SAMPLE_BITS] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/mp2a_win_scan.sv
// window scanner: reads one column per cycle, reduces it and merges the running maximum
`timescale 1ns / 1ps

module mp2a_win_scan (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  mp2a_pkg::scan_cmd_t               cmd,
  output logic                              rd_en,
  output logic [mp2a_pkg::COL_BITS-1:0]     rd_addr,
  input  logic [mp2a_pkg::WORD_BITS-1:0]    rd_data,
  output mp2a_pkg::scan_res_t               res
);

  localparam int TB = mp2a_pkg::KSIZE_BITS + 1;

  mp2a_pkg::scan_state_t state;
  mp2a_pkg::scan_state_t state_next;

  logic [mp2a_pkg::COL_BITS-1:0]   col0;
  logic [mp2a_pkg::KSIZE_BITS-1:0] ksize;
  logic [mp2a_pkg::LANE_BITS-1:0]  lane0;
  logic [mp2a_pkg::LANE_BITS-1:0]  col_idx;
  logic                            issue_last;
  logic [TB-1:0]                   lane_base;

  logic                            rd_vld;
  logic                            rd_last;
  logic [mp2a_pkg::LANE_BITS-1:0]  rd_col;

  logic                                   cb_vld;
  logic                                   cb_last;
  logic [mp2a_pkg::LANE_BITS-1:0]         cb_col;
  logic [mp2a_pkg::LANE_BITS-1:0]         cb_row;
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] cb_val;

  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] col_best;
  logic [mp2a_pkg::LANE_BITS-1:0]         col_best_row;

  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] best_val;
  logic [mp2a_pkg::LANE_BITS-1:0]         best_row;
  logic [mp2a_pkg::LANE_BITS-1:0]         best_col;
  logic                                   done;

  // lane of the window's top row: current lane minus (k - 1), modulo the lane count
  always_comb begin
    lane_base = TB'(cmd.lane_top) + TB'(mp2a_pkg::MAX_KERNEL) + TB'(1) - TB'(cmd.ksize);
    if (lane_base >= TB'(mp2a_pkg::MAX_KERNEL)) begin
      lane_base = lane_base - TB'(mp2a_pkg::MAX_KERNEL);
    end
  end

  assign issue_last = (mp2a_pkg::KSIZE_BITS'(col_idx) == ksize - mp2a_pkg::KSIZE_BITS'(1));

  always_ff @(posedge clk) begin
    if (start) begin
      col0    <= cmd.col0;
      ksize   <= cmd.ksize;
      lane0   <= lane_base[mp2a_pkg::LANE_BITS-1:0];
      col_idx <= '0;
    end else if (state == mp2a_pkg::SC_ISSUE) begin
      col_idx <= col_idx + mp2a_pkg::LANE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mp2a_pkg::SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mp2a_pkg::SC_IDLE: begin
        if (start) state_next = mp2a_pkg::SC_ISSUE;
      end
      mp2a_pkg::SC_ISSUE: begin
        if (issue_last) state_next = mp2a_pkg::SC_DRAIN;
      end
      mp2a_pkg::SC_DRAIN: begin
        if (done) state_next = mp2a_pkg::SC_IDLE;
      end
      default: state_next = mp2a_pkg::SC_IDLE;
    endcase
  end

  always_comb begin
    rd_en   = (state == mp2a_pkg::SC_ISSUE);
    rd_addr = col0 + mp2a_pkg::COL_BITS'(col_idx);
  end

  // column reduce: strict compare keeps the upper row on ties
  always_comb begin
    logic [mp2a_pkg::LANE_BITS:0]            lsum;
    logic [mp2a_pkg::LANE_BITS-1:0]          lane;
    logic signed [mp2a_pkg::SAMPLE_BITS-1:0] v;
    col_best     = '0;
    col_best_row = '0;
    for (int i = 0; i < mp2a_pkg::MAX_KERNEL; i++) begin
      lsum = {1'b0, lane0} + (mp2a_pkg::LANE_BITS+1)'(i);
      if (lsum >= (mp2a_pkg::LANE_BITS+1)'(mp2a_pkg::MAX_KERNEL)) begin
        lsum = lsum - (mp2a_pkg::LANE_BITS+1)'(mp2a_pkg::MAX_KERNEL);
      end
      lane = lsum[mp2a_pkg::LANE_BITS-1:0];
      v    = $signed(rd_data[lane*mp2a_pkg::SAMPLE_BITS +: mp2a_pkg::SAMPLE_BITS]);
      if (i == 0 || (mp2a_pkg::KSIZE_BITS'(i) < ksize && v > col_best)) begin
        col_best     = v;
        col_best_row = mp2a_pkg::LANE_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      rd_last <= 1'b0;
      cb_vld  <= 1'b0;
      cb_last <= 1'b0;
      done    <= 1'b0;
    end else begin
      rd_vld  <= rd_en;
      rd_last <= rd_en && issue_last;
      cb_vld  <= rd_vld;
      cb_last <= rd_vld && rd_last;
      done    <= cb_vld && cb_last;
    end
  end

  always_ff @(posedge clk) begin
    rd_col <= col_idx;
    cb_col <= rd_col;
    cb_row <= col_best_row;
    cb_val <= col_best;
    // a later column wins on a tie only when its maximum sits in an upper row
    if (cb_vld && (cb_col == '0 || cb_val > best_val ||
                   (cb_val == best_val && cb_row < best_row))) begin
      best_val <= cb_val;
      best_row <= cb_row;
      best_col <= cb_col;
    end
  end

  always_comb begin
    res.done    = done;
    res.value   = best_val;
    res.row_off = best_row;
    res.col_off = best_col;
  end

endmodule
